>>> design/stereo_sample_fifo_pwm_feed_macros.svh
// Assertion macros for the stereo sample feed.
// Each expects clk and rst_n in the scope where it is used.
`ifndef STEREO_SAMPLE_FIFO_PWM_FEED_MACROS_SVH
`define STEREO_SAMPLE_FIFO_PWM_FEED_MACROS_SVH

// Same-cycle implication.
`define SFPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfpf assertion failed");

// Next-cycle implication.
`define SFPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfpf assertion failed");

// Delayed implication.
`define SFPF_ASSERT_LATER(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("sfpf assertion failed");

`endif

>>> design/sfpf_pkg.sv
package sfpf_pkg;

    localparam int DEPTH  = 2048;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SMP_W  = 8;
    localparam int DUTY_W = 12;
    localparam int FUNC_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH    = 2'd0,
        FN_TICK    = 2'd1,
        FN_SILENCE = 2'd2
    } func_t;

    // what the ring stage hands to the duty stage
    typedef struct packed {
        logic  valid;
        func_t func;
        logic  push_ok;
        logic  pop;
        logic  en;
    } stage_t;

endpackage

>>> design/sfpf_sample_if.sv
interface sfpf_sample_if
    import sfpf_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [FUNC_W-1:0] func;
    logic [SMP_W-1:0]  left_sample;
    logic [SMP_W-1:0]  right_sample;

    modport source (output valid, func, left_sample, right_sample, input ready);
    modport sink   (input valid, func, left_sample, right_sample, output ready);
endinterface

>>> design/sfpf_duty_if.sv
interface sfpf_duty_if
    import sfpf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              duty_valid;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;

    modport source (output valid, accepted, duty_valid, left_duty, right_duty, input ready);
    modport sink   (input valid, accepted, duty_valid, left_duty, right_duty, output ready);
endinterface

>>> design/sfpf_ring.sv
module sfpf_ring
    import sfpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             step,
    input  logic             take,
    input  logic [FUNC_W-1:0] func,
    input  logic [SMP_W-1:0]  left_sample,
    input  logic [SMP_W-1:0]  right_sample,
    output stage_t           stage,
    output logic [SMP_W-1:0]  rd_left,
    output logic [SMP_W-1:0]  rd_right
);

    logic [2*SMP_W-1:0] mem [DEPTH];
    logic [2*SMP_W-1:0] rd_data_reg;

    logic             enable_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    stage_t           stage_reg, stage_next;

    logic [PTR_W-1:0] rd_inc, wr_inc;
    logic             full, empty, push_ok, pop;
    func_t            fn;

    assign fn     = func_t'(func);
    assign rd_inc = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_inc = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign full   = (wr_inc == rd_ptr_reg);
    assign empty  = (rd_ptr_reg == wr_ptr_reg);

    assign push_ok = take && (fn == FN_PUSH) && enable_reg && !full;
    assign pop     = take && (fn == FN_TICK) && enable_reg && !empty;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (push_ok)
        begin
            wr_ptr_next = wr_inc;
        end
        if (pop)
        begin
            rd_ptr_next = rd_inc;
        end
        if (take && (fn == FN_SILENCE))
        begin
            rd_ptr_next = wr_ptr_reg;
        end

        stage_next.valid   = take;
        stage_next.func    = fn;
        stage_next.push_ok = push_ok;
        stage_next.pop     = pop;
        stage_next.en      = enable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            stage_reg  <= '0;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_wdata;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else if (step)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            stage_reg  <= stage_next;
        end
    end

    // sample store, no reset
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= {left_sample, right_sample};
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign stage    = stage_reg;
    assign rd_left  = rd_data_reg[2*SMP_W-1:SMP_W];
    assign rd_right = rd_data_reg[SMP_W-1:0];

endmodule

>>> design/sfpf_duty.sv
module sfpf_duty
    import sfpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              step,
    input  stage_t            stage,
    input  logic [SMP_W-1:0]  rd_left,
    input  logic [SMP_W-1:0]  rd_right,
    output logic              valid,
    output logic              accepted,
    output logic              duty_valid,
    output logic [DUTY_W-1:0] left_duty,
    output logic [DUTY_W-1:0] right_duty
);

    logic [SMP_W-1:0]  held_l_reg, held_l_next;
    logic [SMP_W-1:0]  held_r_reg, held_r_next;
    logic              valid_reg;
    logic              acc_reg, acc_next;
    logic              dv_reg, dv_next;
    logic [DUTY_W-1:0] ld_reg, ld_next;
    logic [DUTY_W-1:0] rd_reg, rd_next;

    always_comb
    begin
        held_l_next = held_l_reg;
        held_r_next = held_r_reg;
        acc_next    = 1'b0;
        dv_next     = 1'b0;
        ld_next     = '0;
        rd_next     = '0;
        case (stage.func)
            FN_PUSH:
            begin
                acc_next = stage.push_ok;
            end
            FN_TICK:
            begin
                if (stage.pop)
                begin
                    held_l_next = rd_left;
                    held_r_next = rd_right;
                end
                if (stage.en)
                begin
                    dv_next = 1'b1;
                    ld_next = {held_l_next, 4'b0000};
                    rd_next = {held_r_next, 4'b0000};
                end
            end
            FN_SILENCE:
            begin
                held_l_next = '0;
                held_r_next = '0;
                dv_next     = stage.en;
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_l_reg <= '0;
            held_r_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            held_l_reg <= '0;
            held_r_reg <= '0;
        end
        else if (step)
        begin
            valid_reg <= stage.valid;
            if (stage.valid)
            begin
                held_l_reg <= held_l_next;
                held_r_reg <= held_r_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && stage.valid)
        begin
            acc_reg <= acc_next;
            dv_reg  <= dv_next;
            ld_reg  <= ld_next;
            rd_reg  <= rd_next;
        end
    end

    assign valid      = valid_reg;
    assign accepted   = acc_reg;
    assign duty_valid = dv_reg;
    assign left_duty  = ld_reg;
    assign right_duty = rd_reg;

endmodule

>>> design/stereo_sample_fifo_pwm_feed.sv
// Stereo sample ring feeding two PWM duty values.
// samples (sink): one transaction per command; func selects push of a
//   left/right pair, playback tick or silence. A transaction is taken on
//   any edge where valid and ready are both high.
// duty (source): exactly one result transaction per command, in order:
//   accepted flag for pushes, duty_valid plus 12-bit duties (sample x 16)
//   for ticks and silence.
// cfg_we / cfg_wdata: enable register; a write also empties the ring and
//   zeroes the held pair. Users write it only while the block is idle; unchecked.
// A taken command moves to the ring's stage register, then to the result
//   register on duty. Throughput: one transaction per cycle unless duty stalls;
//   each makes at most one store access: a push write or a registered pop read.
// The ring holds 2047 pairs in a 2048-entry store.
// Reset: pointers, held pair and enable clear at once; no clearing pass,
//   as only written entries are ever read.
// Stall: when duty is held off the whole pipe freezes and samples.ready
//   drops in the same cycle; nothing is lost or repeated.
module stereo_sample_fifo_pwm_feed
    import sfpf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    sfpf_sample_if.sink   samples,
    sfpf_duty_if.source   duty
);

    stage_t           stage;
    logic [SMP_W-1:0] rd_left, rd_right;
    logic             step, take;

    // the pipe moves whenever the result register is free or being emptied
    assign step          = !duty.valid || duty.ready;
    assign samples.ready = step;
    assign take          = step && samples.valid;

    // pointers, store and the registered read
    sfpf_ring u_ring (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .step         (step),
        .take         (take),
        .func         (samples.func),
        .left_sample  (samples.left_sample),
        .right_sample (samples.right_sample),
        .stage        (stage),
        .rd_left      (rd_left),
        .rd_right     (rd_right)
    );

    // held pair and the result register
    sfpf_duty u_duty (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .step       (step),
        .stage      (stage),
        .rd_left    (rd_left),
        .rd_right   (rd_right),
        .valid      (duty.valid),
        .accepted   (duty.accepted),
        .duty_valid (duty.duty_valid),
        .left_duty  (duty.left_duty),
        .right_duty (duty.right_duty)
    );

endmodule

>>> design/sfpf_checker.sv
`include "stereo_sample_fifo_pwm_feed_macros.svh"

module sfpf_checker
    import sfpf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              accepted,
    input logic              duty_valid,
    input logic [DUTY_W-1:0] left_duty,
    input logic [DUTY_W-1:0] right_duty
);

    // stalled result holds
    `SFPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accepted) && $stable(duty_valid) && $stable(left_duty) && $stable(right_duty))
    // a push result never carries duties
    `SFPF_ASSERT_NOW(a_push_clean, out_valid && accepted, !duty_valid && left_duty == '0 && right_duty == '0)
    // duties only with duty_valid, low nibble always zero
    `SFPF_ASSERT_NOW(a_duty_zero, out_valid && !duty_valid, left_duty == '0 && right_duty == '0)
    `SFPF_ASSERT_NOW(a_duty_lsb, out_valid, left_duty[3:0] == 4'd0 && right_duty[3:0] == 4'd0)
    // a taken command is followed later by a valid result
    `SFPF_ASSERT_LATER(a_latency, in_valid && in_ready, out_valid)

endmodule

bind stereo_sample_fifo_pwm_feed sfpf_checker u_sfpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (duty.valid),
    .out_ready  (duty.ready),
    .accepted   (duty.accepted),
    .duty_valid (duty.duty_valid),
    .left_duty  (duty.left_duty),
    .right_duty (duty.right_duty)
);
